### src/pmcv_pkg.sv
// ----------------------------------------------------------------------------
// pmcv_pkg
// Shared types and codes for the paged mode CV programming sequencer: beat
// layouts of both channels, sequencer state record and its reset value.
// ----------------------------------------------------------------------------
package pmcv_pkg;

  // highest CV number a start request may name
  localparam logic [10:0] MAX_CV = 11'd1024;

  // request codes
  localparam logic [2:0] REQ_RD_BYTE = 3'd0;
  localparam logic [2:0] REQ_WR_BYTE = 3'd1;
  localparam logic [2:0] REQ_RD_BIT  = 3'd2;
  localparam logic [2:0] REQ_WR_BIT  = 3'd3;
  localparam logic [2:0] REQ_PRIM    = 3'd4;
  localparam logic [2:0] REQ_REFUSED = 3'd5;

  // completion status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_VFY_FAIL  = 2'd3;

  // progress phase codes
  localparam logic [1:0] PROG_READ   = 2'd0;
  localparam logic [1:0] PROG_WRITE  = 2'd1;
  localparam logic [1:0] PROG_VERIFY = 2'd2;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RD    = 3'd1,
    PH_WR    = 3'd2,
    PH_WRV   = 3'd3,
    PH_RB    = 3'd4,
    PH_WB_RD = 3'd5,
    PH_WB_WR = 3'd6,
    PH_WB_V  = 3'd7
  } phase_t;

  // input beat
  typedef struct packed {
    logic [2:0]  req_type;
    logic [10:0] cv_address;
    logic [3:0]  bit_index;
    logic [7:0]  write_byte;
    logic        bit_level;
    logic        ack_seen;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic        start_accepted;
    logic        start_withdrawn;
    logic        cmd_valid;
    logic        cmd_is_write;
    logic [10:0] cmd_cv;
    logic [7:0]  cmd_data;
    logic        progress_valid;
    logic [1:0]  progress_phase;
    logic [7:0]  progress_step;
    logic        done_valid;
    logic [1:0]  done_status;
    logic [7:0]  done_value;
  } out_item_t;

  // sequencer state
  typedef struct packed {
    phase_t      phase;
    logic [10:0] target_cv;
    logic [2:0]  target_bit;
    logic        target_bit_level;
    logic [7:0]  work_byte;
    logic [7:0]  scan_byte;
    logic [7:0]  step_count;
    logic        first_cmd_pending;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    phase:             PH_IDLE,
    target_cv:         11'd0,
    target_bit:        3'd0,
    target_bit_level:  1'b0,
    work_byte:         8'd0,
    scan_byte:         8'd0,
    step_count:        8'd0,
    first_cmd_pending: 1'b0
  };

endpackage

### src/paged_mode_cv_programming_sequencer.sv
// ----------------------------------------------------------------------------
// paged_mode_cv_programming_sequencer
// Paged service mode CV read/write sequencer, one result beat per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries start requests (read/write byte, read/write bit) and track
//         events (primitive done with ack flag, issue refused).
//   out_* returns exactly one result beat per input beat, in order: start
//         accept/withdraw flags, an optional paged verify/write command,
//         an optional progress report and an optional completion.
//   Both channels use valid/stall; a beat moves when valid is high and
//   stall is low.
//   Path: an accepted beat waits in the input register; its result
//   goes from the step logic into the result register, which drives out_*.
//   Throughput: one beat per cycle while out_stall is low.
//   Stall: while out_stall holds a result, one more input beat is taken into
//   the input register, then in_stall rises until the result moves on.
//   Reset (rst_n low, synchronous): sequencer returns to idle, both pipeline
//   stages empty, step counter and targets cleared.
// ----------------------------------------------------------------------------
module paged_mode_cv_programming_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pmcv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pmcv_pkg::out_item_t out_data
);
  import pmcv_pkg::*;

  logic       in_valid_r;
  in_item_t   in_data_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  out_item_t  res_nxt;
  logic       adv;

  // step logic
  pmcv_step u_step (
    .cur  (state_r),
    .item (in_data_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // pipeline advance when the result slot is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !adv;

  // control and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (adv && in_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/pmcv_step.sv
// ----------------------------------------------------------------------------
// pmcv_step
// Next-state and result logic for one beat: start checks, scan advance,
// read-modify-write of a bit, write and verify, refusal handling.
// ----------------------------------------------------------------------------
module pmcv_step (
  input  pmcv_pkg::seq_state_t cur,
  input  pmcv_pkg::in_item_t   item,
  output pmcv_pkg::seq_state_t nxt,
  output pmcv_pkg::out_item_t  res
);
  import pmcv_pkg::*;

  logic       is_start;
  logic       is_bit_req;
  logic       start_ok;
  logic [7:0] step_inc;
  logic [7:0] bit_mask;
  logic [7:0] mod_byte;
  logic [7:0] scan_inc;

  // start request decode and range check
  assign is_start   = (item.req_type == REQ_RD_BYTE) || (item.req_type == REQ_WR_BYTE) ||
                      (item.req_type == REQ_RD_BIT)  || (item.req_type == REQ_WR_BIT);
  assign is_bit_req = (item.req_type == REQ_RD_BIT) || (item.req_type == REQ_WR_BIT);
  assign start_ok   = (cur.phase == PH_IDLE) && (item.cv_address != 11'd0) &&
                      (item.cv_address <= MAX_CV) &&
                      !(is_bit_req && item.bit_index[3]);

  // shared arithmetic
  assign step_inc = cur.step_count + 8'd1;
  assign scan_inc = cur.scan_byte + 8'd1;
  assign bit_mask = 8'd1 << cur.target_bit;
  assign mod_byte = cur.target_bit_level ? (cur.scan_byte | bit_mask)
                                         : (cur.scan_byte & ~bit_mask);

  always_comb begin
    nxt = cur;
    res = '0;
    if (is_start) begin
      // start: when the checks pass, latch target and issue first command
      if (start_ok) begin
        nxt.target_cv         = item.cv_address;
        nxt.step_count        = 8'd0;
        nxt.first_cmd_pending = 1'b1;
        res.start_accepted    = 1'b1;
        res.cmd_valid         = 1'b1;
        res.cmd_cv            = item.cv_address;
        if (item.req_type == REQ_WR_BYTE) begin
          nxt.work_byte    = item.write_byte;
          nxt.phase        = PH_WR;
          res.cmd_is_write = 1'b1;
          res.cmd_data     = item.write_byte;
        end else begin
          nxt.scan_byte = 8'd0;
          case (item.req_type)
            REQ_RD_BYTE: nxt.phase = PH_RD;
            REQ_RD_BIT: begin
              nxt.target_bit = item.bit_index[2:0];
              nxt.phase      = PH_RB;
            end
            default: begin
              nxt.target_bit       = item.bit_index[2:0];
              nxt.target_bit_level = item.bit_level;
              nxt.phase            = PH_WB_RD;
            end
          endcase
        end
      end
    end else if (item.req_type == REQ_PRIM) begin
      // primitive done: advance the task
      nxt.first_cmd_pending = 1'b0;
      res.cmd_cv            = cur.target_cv;
      case (cur.phase)
        PH_RD, PH_RB, PH_WB_RD: begin
          nxt.step_count     = step_inc;
          res.progress_valid = 1'b1;
          res.progress_phase = PROG_READ;
          res.progress_step  = step_inc;
          if (item.ack_seen) begin
            if (cur.phase == PH_RD) begin
              nxt.phase       = PH_IDLE;
              res.done_valid  = 1'b1;
              res.done_status = ST_OK;
              res.done_value  = cur.scan_byte;
            end else if (cur.phase == PH_RB) begin
              nxt.phase       = PH_IDLE;
              res.done_valid  = 1'b1;
              res.done_status = ST_OK;
              res.done_value  = {7'd0, cur.scan_byte[cur.target_bit]};
            end else begin
              nxt.work_byte    = mod_byte;
              nxt.phase        = PH_WB_WR;
              res.cmd_valid    = 1'b1;
              res.cmd_is_write = 1'b1;
              res.cmd_data     = mod_byte;
            end
          end else if (cur.scan_byte == 8'hFF) begin
            nxt.phase       = PH_IDLE;
            res.done_valid  = 1'b1;
            res.done_status = ST_NOT_FOUND;
          end else begin
            nxt.scan_byte = scan_inc;
            res.cmd_valid = 1'b1;
            res.cmd_data  = scan_inc;
          end
        end
        PH_WR: begin
          nxt.step_count     = step_inc;
          res.progress_valid = 1'b1;
          res.progress_phase = PROG_WRITE;
          res.progress_step  = step_inc;
          nxt.phase          = PH_WRV;
          res.cmd_valid      = 1'b1;
          res.cmd_data       = cur.work_byte;
        end
        PH_WRV: begin
          nxt.step_count     = step_inc;
          res.progress_valid = 1'b1;
          res.progress_phase = PROG_VERIFY;
          res.progress_step  = step_inc;
          nxt.phase          = PH_IDLE;
          res.done_valid     = 1'b1;
          res.done_status    = item.ack_seen ? ST_OK : ST_VFY_FAIL;
          res.done_value     = cur.work_byte;
        end
        PH_WB_WR: begin
          nxt.phase     = PH_WB_V;
          res.cmd_valid = 1'b1;
          res.cmd_data  = cur.work_byte;
        end
        PH_WB_V: begin
          nxt.phase       = PH_IDLE;
          res.done_valid  = 1'b1;
          res.done_status = item.ack_seen ? ST_OK : ST_VFY_FAIL;
          res.done_value  = {7'd0, cur.target_bit_level};
        end
        default: ;
      endcase
      // cmd fields read zero unless a command goes out
      if (!res.cmd_valid) begin
        res.cmd_cv = 11'd0;
      end
    end else if (item.req_type == REQ_REFUSED) begin
      // refusal of the command issued last
      if (cur.phase != PH_IDLE) begin
        nxt.phase = PH_IDLE;
        if (cur.first_cmd_pending) begin
          nxt.first_cmd_pending = 1'b0;
          res.start_withdrawn   = 1'b1;
        end else begin
          res.done_valid  = 1'b1;
          res.done_status = ST_BUSY;
        end
      end
    end
  end

endmodule

### src/pmcv_checker.sv
// ----------------------------------------------------------------------------
// pmcv_checker
// Port-level checks on the result channel of the CV programming sequencer.
// ----------------------------------------------------------------------------
module pmcv_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input pmcv_pkg::out_item_t out_data
);
  import pmcv_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // an issued command names a CV in range
  a_cmd_cv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cmd_valid |-> (out_data.cmd_cv != 11'd0) &&
      (out_data.cmd_cv <= MAX_CV))
    else $error("command with CV out of range");

  // no command means zero command fields
  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cmd_valid |-> (out_data.cmd_cv == 11'd0) &&
      (out_data.cmd_data == 8'd0) && !out_data.cmd_is_write)
    else $error("command fields set without command");

  // a withdrawn start carries no command and no completion
  a_withdraw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.start_withdrawn |-> !out_data.cmd_valid &&
      !out_data.done_valid && !out_data.start_accepted)
    else $error("withdrawn start with command or completion");

  // a completion never comes with an accepted start or a command
  a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_valid |-> !out_data.start_accepted &&
      !out_data.cmd_valid)
    else $error("completion together with start or command");

endmodule

bind paged_mode_cv_programming_sequencer pmcv_checker u_pmcv_checker (.*);

### bench/paged_mode_cv_programming_sequencer_tb.sv
// ----------------------------------------------------------------------------
// paged_mode_cv_programming_sequencer_tb
// Self-checking bench for the paged mode CV programming sequencer. Beats go
// in through the valid/stall input channel. A predictor in the bench tracks
// the sequencer phase, targets, scan value and step counter, and works out
// the expected result beat. Each result beat is compared field by field
// against the oldest expected beat. The stimulus is a set of directed cases
// and then random programming sessions mixed with noise beats. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module paged_mode_cv_programming_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmcv_pkg::*;

  // request code the block does not define
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;

  // predicted sequencer state
  phase_t      cur_phase;
  logic [10:0] tgt_cv;
  logic [2:0]  tgt_bit;
  logic        tgt_level;
  logic [7:0]  work_val;
  logic [7:0]  scan_val;
  logic [7:0]  step_val;
  logic        first_pending;

  out_item_t   expected_results[$];
  int unsigned fail_count;
  int unsigned gap_max;
  int unsigned stall_max;

  paged_mode_cv_programming_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void put_command(inout out_item_t r, input logic wr,
                                      input logic [7:0] data);
    r.cmd_valid    = 1'b1;
    r.cmd_is_write = wr;
    r.cmd_cv       = tgt_cv;
    r.cmd_data     = data;
  endfunction

  function automatic void put_progress(inout out_item_t r, input logic [1:0] ph);
    step_val         = step_val + 8'd1;
    r.progress_valid = 1'b1;
    r.progress_phase = ph;
    r.progress_step  = step_val;
  endfunction

  function automatic void put_done(inout out_item_t r, input logic [1:0] st,
                                   input logic [7:0] value);
    cur_phase     = PH_IDLE;
    r.done_valid  = 1'b1;
    r.done_status = st;
    r.done_value  = value;
  endfunction

  // next result beat of the sequencer for one accepted input beat
  function automatic out_item_t sequencer_next(input in_item_t b);
    out_item_t  r;
    logic       is_bit_req;
    logic [7:0] modified;
    r = '0;
    case (b.req_type)
      REQ_RD_BYTE, REQ_WR_BYTE, REQ_RD_BIT, REQ_WR_BIT: begin
        is_bit_req = (b.req_type == REQ_RD_BIT) || (b.req_type == REQ_WR_BIT);
        if (cur_phase == PH_IDLE && b.cv_address != 11'd0 && b.cv_address <= MAX_CV &&
            !(is_bit_req && b.bit_index > 4'd7)) begin
          tgt_cv           = b.cv_address;
          step_val         = 8'd0;
          first_pending    = 1'b1;
          r.start_accepted = 1'b1;
          if (b.req_type == REQ_WR_BYTE) begin
            work_val  = b.write_byte;
            cur_phase = PH_WR;
            put_command(r, 1'b1, b.write_byte);
          end else begin
            scan_val = 8'd0;
            if (b.req_type == REQ_RD_BYTE) begin
              cur_phase = PH_RD;
            end else if (b.req_type == REQ_RD_BIT) begin
              tgt_bit   = b.bit_index[2:0];
              cur_phase = PH_RB;
            end else begin
              tgt_bit   = b.bit_index[2:0];
              tgt_level = b.bit_level;
              cur_phase = PH_WB_RD;
            end
            put_command(r, 1'b0, 8'd0);
          end
        end
      end
      REQ_PRIM: begin
        first_pending = 1'b0;
        case (cur_phase)
          PH_RD, PH_RB, PH_WB_RD: begin
            put_progress(r, PROG_READ);
            if (b.ack_seen) begin
              if (cur_phase == PH_RD) begin
                put_done(r, ST_OK, scan_val);
              end else if (cur_phase == PH_RB) begin
                put_done(r, ST_OK, {7'd0, scan_val[tgt_bit]});
              end else begin
                // read found the byte: write it back with the target bit at the target level
                modified          = scan_val;
                modified[tgt_bit] = tgt_level;
                work_val          = modified;
                cur_phase         = PH_WB_WR;
                put_command(r, 1'b1, modified);
              end
            end else if (scan_val == 8'hFF) begin
              put_done(r, ST_NOT_FOUND, 8'd0);
            end else begin
              scan_val = scan_val + 8'd1;
              put_command(r, 1'b0, scan_val);
            end
          end
          PH_WR: begin
            put_progress(r, PROG_WRITE);
            cur_phase = PH_WRV;
            put_command(r, 1'b0, work_val);
          end
          PH_WRV: begin
            put_progress(r, PROG_VERIFY);
            put_done(r, b.ack_seen ? ST_OK : ST_VFY_FAIL, work_val);
          end
          PH_WB_WR: begin
            cur_phase = PH_WB_V;
            put_command(r, 1'b0, work_val);
          end
          PH_WB_V: begin
            put_done(r, b.ack_seen ? ST_OK : ST_VFY_FAIL, {7'd0, tgt_level});
          end
          default: ;
        endcase
      end
      REQ_REFUSED: begin
        if (cur_phase != PH_IDLE) begin
          if (first_pending) begin
            first_pending     = 1'b0;
            cur_phase         = PH_IDLE;
            r.start_withdrawn = 1'b1;
          end else begin
            put_done(r, ST_BUSY, 8'd0);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic in_item_t make_beat(input logic [2:0] req, input logic [10:0] cv,
                                         input logic [3:0] bidx, input logic [7:0] wbyte,
                                         input logic lvl, input logic ack);
    in_item_t b;
    b.req_type   = req;
    b.cv_address = cv;
    b.bit_index  = bidx;
    b.write_byte = wbyte;
    b.bit_level  = lvl;
    b.ack_seen   = ack;
    return b;
  endfunction

  // present one beat after a random gap, predict its result once taken
  task automatic send_beat(input in_item_t beat);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(sequencer_next(beat));
  endtask

  // hold off the input until every expected result beat has come out
  task automatic wait_results_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall before each result beat
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = $urandom_range(0, stall_max);
      if (hold != 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [10:0] want,
                                      input logic [10:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t ns: %s expected %0d got %0d", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t ns: result beat %h with nothing expected", $realtime, out_data);
      end else begin
        want = expected_results.pop_front();
        check_field("start_accepted", 11'(want.start_accepted),
                    11'(out_data.start_accepted));
        check_field("start_withdrawn", 11'(want.start_withdrawn),
                    11'(out_data.start_withdrawn));
        check_field("cmd_valid", 11'(want.cmd_valid), 11'(out_data.cmd_valid));
        check_field("cmd_is_write", 11'(want.cmd_is_write), 11'(out_data.cmd_is_write));
        check_field("cmd_cv", want.cmd_cv, out_data.cmd_cv);
        check_field("cmd_data", 11'(want.cmd_data), 11'(out_data.cmd_data));
        check_field("progress_valid", 11'(want.progress_valid),
                    11'(out_data.progress_valid));
        check_field("progress_phase", 11'(want.progress_phase),
                    11'(out_data.progress_phase));
        check_field("progress_step", 11'(want.progress_step),
                    11'(out_data.progress_step));
        check_field("done_valid", 11'(want.done_valid), 11'(out_data.done_valid));
        check_field("done_status", 11'(want.done_status), 11'(out_data.done_status));
        check_field("done_value", 11'(want.done_value), 11'(out_data.done_value));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // starts that must be refused and events that must be ignored while idle
  task automatic test_refused_requests();
    send_beat(make_beat(REQ_RD_BYTE, 11'd0, 4'd0, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_WR_BYTE, 11'd1025, 4'd0, 8'hFF, 1'b1, 1'b1));
    send_beat(make_beat(REQ_RD_BIT, 11'd1, 4'd8, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_WR_BIT, 11'd1024, 4'd15, 8'hFF, 1'b1, 1'b1));
    send_beat(make_beat(REQ_REFUSED, 11'd5, 4'd0, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_PRIM, 11'd5, 4'd0, 8'd0, 1'b0, 1'b1));
    send_beat(make_beat(REQ_UNKNOWN, 11'h7FF, 4'hF, 8'hFF, 1'b1, 1'b1));
    wait_results_drained();
  endtask

  // byte read acked on the first verify, bit fields ignored
  task automatic test_read_byte();
    send_beat(make_beat(REQ_RD_BYTE, 11'd1, 4'd15, 8'h5A, 1'b1, 1'b0));
    send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b1));
    wait_results_drained();
  endtask

  // byte write at the top CV whose verify gets no ack
  task automatic test_write_byte();
    send_beat(make_beat(REQ_WR_BYTE, 11'd1024, 4'd0, 8'hFF, 1'b0, 1'b0));
    send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b1));
    send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b0));
    wait_results_drained();
  endtask

  // bit read of bit 7, found on the second verify
  task automatic test_read_bit();
    send_beat(make_beat(REQ_RD_BIT, 11'd512, 4'd7, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b1));
    wait_results_drained();
  endtask

  // bit write: read, modified write, verify
  task automatic test_write_bit();
    send_beat(make_beat(REQ_WR_BIT, 11'd2, 4'd0, 8'd0, 1'b1, 1'b0));
    send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b1));
    send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b1));
    wait_results_drained();
  endtask

  // start while busy, refusal of the first command, refusal later on
  task automatic test_command_refusal();
    send_beat(make_beat(REQ_RD_BYTE, 11'd100, 4'd0, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_WR_BYTE, 11'd5, 4'd0, 8'h33, 1'b0, 1'b0));
    send_beat(make_beat(REQ_REFUSED, 11'd0, 4'd0, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_WR_BIT, 11'd7, 4'd3, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b0));
    send_beat(make_beat(REQ_REFUSED, 11'd0, 4'd0, 8'd0, 1'b0, 1'b0));
    wait_results_drained();
  endtask

  // full scan without any ack: not found, step counter wraps
  task automatic test_scan_exhausted();
    gap_max   = 2;
    stall_max = 2;
    send_beat(make_beat(REQ_RD_BYTE, 11'd1024, 4'd0, 8'd0, 1'b0, 1'b0));
    repeat (256) send_beat(make_beat(REQ_PRIM, 11'd0, 4'd0, 8'd0, 1'b0, 1'b0));
    wait_results_drained();
  endtask

  function automatic logic [10:0] pick_cv();
    case ($urandom_range(0, 9))
      0:       return 11'd1;
      1:       return MAX_CV;
      default: return 11'($urandom_range(1, 1024));
    endcase
  endfunction

  // random sessions with random content, some noise beats in between
  task automatic test_random_sessions(input int unsigned n_items);
    int unsigned sent;
    in_item_t    b;
    logic [7:0]  ack_at;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      // idling profile changes now and then, including no idling at all
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: begin gap_max = 0;  stall_max = 0;  end
          1: begin gap_max = 10; stall_max = 0;  end
          2: begin gap_max = 0;  stall_max = 10; end
          default: begin gap_max = 10; stall_max = 10; end
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        b = in_item_t'($urandom);
        send_beat(b);
        sent++;
      end else begin
        b            = in_item_t'($urandom);
        b.req_type   = 3'($urandom_range(0, 3));
        b.cv_address = pick_cv();
        b.bit_index  = 4'($urandom_range(0, 7));
        ack_at       = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        send_beat(b);
        sent++;
        while (cur_phase != PH_IDLE) begin
          b    = in_item_t'($urandom);
          pick = $urandom_range(0, 39);
          if (pick == 0) begin
            b.req_type = REQ_REFUSED;
          end else if (pick == 1) begin
            b.req_type   = 3'($urandom_range(0, 3));
            b.cv_address = pick_cv();
          end else begin
            b.req_type = REQ_PRIM;
            if (cur_phase == PH_RD || cur_phase == PH_RB || cur_phase == PH_WB_RD)
              b.ack_seen = (scan_val == ack_at);
            else
              b.ack_seen = ($urandom_range(0, 4) != 0);
          end
          send_beat(b);
          sent++;
        end
        if ($urandom_range(0, 15) == 0) wait_results_drained();
      end
    end
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    cur_phase     = PH_IDLE;
    tgt_cv        = 11'd0;
    tgt_bit       = 3'd0;
    tgt_level     = 1'b0;
    work_val      = 8'd0;
    scan_val      = 8'd0;
    step_val      = 8'd0;
    first_pending = 1'b0;
    fail_count    = 0;
    gap_max       = 10;
    stall_max     = 10;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_refused_requests();
    test_read_byte();
    test_write_byte();
    test_read_bit();
    test_write_bit();
    test_command_refusal();
    test_scan_exhausted();
    test_random_sessions(660);

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("paged_mode_cv_programming_sequencer_tb passed");
    end else begin
      $display("paged_mode_cv_programming_sequencer_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("paged_mode_cv_programming_sequencer_tb failed");
    $finish;
  end

endmodule
